[sv/pars_pkg.sv]
// Package for the probe-and-adapt rate selector: shared constants and types.
// No dependencies.
`default_nettype none
package pars_pkg;
    localparam int LADDER_DEPTH_DEF = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [2:0] REG_ALPHA = 3'd0;
    localparam logic [2:0] REG_BETA  = 3'd1;
    localparam logic [2:0] REG_KAPPA = 3'd2;
    localparam logic [2:0] REG_W     = 3'd3;
    localparam logic [2:0] REG_EPS   = 3'd4;
    localparam logic [2:0] REG_BMIN  = 3'd5;
    localparam logic [2:0] REG_SEG   = 3'd6;
    localparam logic [2:0] REG_COUNT = 3'd7;
    localparam logic OP_LOAD = 1'b0;

    typedef struct packed {
        logic [0:0]  op;
        logic [3:0]  entry_index;
        logic [31:0] entry_rate;
        logic [31:0] measured_rate;
        logic [31:0] fetch_time;
        logic [15:0] buffer_level;
    } t_in;

    typedef struct packed {
        logic [3:0]  chosen_index;
        logic [31:0] chosen_rate;
        logic [31:0] probe_rate;
        logic [31:0] smoothed_rate;
        logic [31:0] request_interval;
    } t_out;
endpackage
`default_nettype wire

[sv/pars_if.sv]
// Valid/ready channel interface carrying one payload of type T.
// Depends on nothing; payload type is set by the user.
`default_nettype none
interface pars_if #(parameter type T = logic) (input wire logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/probe_and_adapt_rate_selector_core.sv]
// Top level of the probe-and-adapt rate selector.
// Depends on pars_pkg and pars_if.
// A report is worked by up to six bit-serial multiplies (one multiplier bit a cycle),
// a 64-step restoring divider and a walk over the ladder entries; a ladder load
// goes straight to the result register.
// One item is worked at a time; the next is taken once the result register is free.
// Reset (synchronous, active low) restores register defaults and clears state.
`default_nettype none
module probe_and_adapt_rate_selector_core #(
    parameter int LADDER_DEPTH = pars_pkg::LADDER_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [pars_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [pars_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pars_if.sink                               i_in,
    pars_if.source                             o_out
);
    import pars_pkg::*;

    localparam int AW = $clog2(LADDER_DEPTH);
    localparam int NMAX = (LADDER_DEPTH < 16) ? LADDER_DEPTH : 16;

    // Configuration registers.
    logic [15:0] r_alpha, r_beta, r_kappa, r_eps, r_bmin;
    logic [23:0] r_w, r_seg;
    logic [4:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= 16'd13107; r_beta <= 16'd13107; r_kappa <= 16'd9175;
            r_w <= '0; r_eps <= 16'd9830; r_bmin <= 16'd44;
            r_seg <= 24'd131072; r_count <= 5'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ALPHA: r_alpha <= i_cfg_data[15:0];
                REG_BETA:  r_beta  <= i_cfg_data[15:0];
                REG_KAPPA: r_kappa <= i_cfg_data[15:0];
                REG_W:     r_w     <= i_cfg_data;
                REG_EPS:   r_eps   <= i_cfg_data[15:0];
                REG_BMIN:  r_bmin  <= i_cfg_data[15:0];
                REG_SEG:   r_seg   <= i_cfg_data;
                REG_COUNT: r_count <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Effective ladder size, zero acts as one.
    logic [4:0] n_eff;
    always_comb begin
        n_eff = r_count;
        if (n_eff == 5'd0) n_eff = 5'd1;
        if (n_eff > 5'(NMAX)) n_eff = 5'(NMAX);
    end

    // Ladder memory, read through a registered port.
    logic [31:0] r_ladder [LADDER_DEPTH];
    logic [31:0] r_rd;
    logic [AW-1:0] rd_addr;

    typedef enum logic [3:0] {
        S_IDLE, S_T, S_MUL, S_ACC, S_AVG, S_THR, S_WALK, S_PICK,
        S_DIVSET, S_DIV, S_FIN, S_OUT
    } t_state;

    t_state r_state;
    // Step selects which of the shift-add multiplies is running.
    logic [2:0] r_step;
    logic [31:0] r_tgt, r_avg, r_cur, r_nint;
    logic [3:0]  r_lvl;
    logic [31:0] r_bps, r_t;
    logic [15:0] r_buf;
    // Serial multiplier: accumulator, shifting multiplicand and multiplier.
    logic [63:0] r_acc, r_mcand, r_mplier;
    logic [6:0]  r_cnt;
    logic        r_neg;
    logic signed [49:0] r_d;
    logic signed [49:0] r_thr_up, r_thr_dn;
    logic [4:0]  r_wi;
    logic [3:0]  r_up, r_dn;
    logic        r_up_done, r_dn_done;
    logic [1:0]  r_pick;
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    t_out        r_res;
    logic        r_res_v;

    assign rd_addr = AW'(r_state == S_WALK ? r_wi : (r_pick == 2'd0 ? {1'b0, r_up}
                                                                    : {1'b0, r_dn}));

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready && i_in.data.op == OP_LOAD
            && 32'(i_in.data.entry_index) < 32'(LADDER_DEPTH))
            r_ladder[AW'(i_in.data.entry_index)] <= i_in.data.entry_rate;
        r_rd <= r_ladder[rd_addr];
    end

    assign i_in.ready = (r_state == S_IDLE) && !r_res_v;
    assign o_out.valid = r_res_v;
    assign o_out.data  = r_res;

    logic signed [49:0] sat_in;
    logic [31:0] sat_o;
    always_comb begin
        if (sat_in < 0) sat_o = '0;
        else if (sat_in > 50'sh0_FFFF_FFFF) sat_o = '1;
        else sat_o = sat_in[31:0];
    end

    logic signed [49:0] step_v;
    assign step_v = r_neg ? -$signed({2'b0, 48'((r_acc + 64'hFFFF) >> 16)})
                          : $signed({2'b0, 48'(r_acc >> 16)});
    always_comb begin
        sat_in = (r_step == 3'd1) ? ($signed({18'b0, r_tgt}) + step_v)
                                  : ($signed({18'b0, r_avg}) + step_v);
    end

    logic signed [49:0] rung;
    assign rung = $signed({2'b0, r_rd, 16'b0});

    // Interval: clamped quotient plus signed buffer feedback.
    logic [31:0] q_c;
    logic signed [49:0] fb, nsum;
    logic [31:0] nint_v;
    assign q_c = (r_quo[63:32] != 0) ? 32'hFFFF_FFFF : r_quo[31:0];
    assign fb = $signed({34'b0, r_beta}) *
                ($signed({34'b0, r_buf}) - $signed({34'b0, r_bmin}));
    assign nsum = $signed({18'b0, q_c}) + fb;
    assign nint_v = (nsum < 0) ? 32'd0 : ((nsum > 50'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                                      : nsum[31:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_res_v <= 1'b0;
            r_tgt <= '0; r_avg <= '0; r_cur <= '0; r_lvl <= '0; r_nint <= '0;
        end else begin
            if (o_out.valid && o_out.ready) r_res_v <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_in.valid && i_in.ready) begin
                    if (i_in.data.op == OP_LOAD) begin
                        r_state <= S_OUT;
                    end else begin
                        r_bps <= i_in.data.measured_rate;
                        r_buf <= i_in.data.buffer_level;
                        r_t <= (r_nint > i_in.data.fetch_time) ? r_nint
                                                               : i_in.data.fetch_time;
                        r_state <= S_T;
                    end
                end
                S_T: begin
                    // Step 0: g = kappa * T. A zero target takes the measured rate
                    // and the average update follows directly.
                    if (r_tgt != 0) begin
                        r_step <= 3'd0;
                        r_mplier <= {48'b0, r_kappa};
                        r_d <= $signed({26'b0, r_w}) -
                               ((r_tgt > r_bps) ? $signed({18'b0, r_tgt - r_bps}) : 50'sd0);
                        r_mcand <= {32'b0, r_t};
                        r_acc <= '0; r_cnt <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_tgt <= r_bps;
                        r_state <= S_AVG;
                    end
                end
                S_MUL: begin
                    if (r_mplier[0]) r_acc <= r_acc + r_mcand;
                    r_mcand <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd63) r_state <= S_ACC;
                end
                S_ACC: begin
                    r_cnt <= '0;
                    unique case (r_step)
                        3'd0, 3'd2: begin
                            // g ready; multiply |d| by g.
                            r_mcand <= {32'b0, r_acc[47:16]};
                            r_neg <= r_d[49];
                            r_mplier <= r_d[49] ? 64'(-r_d) : 64'(r_d);
                            r_acc <= '0;
                            r_step <= r_step + 3'd1;
                            r_state <= S_MUL;
                        end
                        3'd1: begin
                            r_tgt <= sat_o;
                            r_state <= S_AVG;
                        end
                        3'd3: begin
                            r_avg <= sat_o;
                            r_state <= S_THR;
                        end
                        3'd4: begin
                            // eps * avg ready.
                            r_thr_up <= r_thr_dn - $signed({2'b0, r_acc[47:0]});
                            r_wi <= '0; r_up_done <= 1'b0; r_dn_done <= 1'b0;
                            r_up <= 4'(n_eff - 5'd1); r_dn <= 4'(n_eff - 5'd1);
                            r_state <= S_WALK;
                        end
                        default: begin
                            // current * seg product ready for division.
                            r_state <= S_DIVSET;
                        end
                    endcase
                end
                S_AVG: begin
                    if (r_avg != 0) begin
                        r_step <= 3'd2;
                        r_mplier <= {48'b0, r_alpha};
                        r_d <= $signed({18'b0, r_tgt}) - $signed({18'b0, r_avg});
                        r_mcand <= {32'b0, r_t};
                        r_acc <= '0; r_cnt <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_avg <= r_tgt;
                        r_state <= S_THR;
                    end
                end
                S_THR: begin
                    r_thr_dn <= $signed({2'b0, r_avg, 16'b0}) - $signed({10'b0, r_w, 16'b0});
                    r_step <= 3'd4;
                    r_mcand <= {32'b0, r_avg};
                    r_mplier <= {48'b0, r_eps};
                    r_acc <= '0; r_cnt <= '0;
                    r_state <= S_MUL;
                end
                S_WALK: begin
                    // r_rd holds entry r_wi-1 from the previous cycle.
                    if (r_wi != 5'd0) begin
                        if (!r_up_done && rung > r_thr_up) begin
                            r_up_done <= 1'b1;
                            r_up <= (r_wi > 5'd1) ? 4'(r_wi - 5'd2) : 4'd0;
                        end
                        if (!r_dn_done && rung > r_thr_dn) begin
                            r_dn_done <= 1'b1;
                            r_dn <= (r_wi > 5'd1) ? 4'(r_wi - 5'd2) : 4'd0;
                        end
                    end
                    if (r_wi == n_eff) begin
                        r_pick <= 2'd0;
                        r_state <= S_PICK;
                    end
                    r_wi <= r_wi + 5'd1;
                end
                S_PICK: begin
                    // The up entry is compared first; only when it does not move
                    // the level is the down entry compared.
                    r_pick <= r_pick + 2'd1;
                    if (r_pick == 2'd1 && r_cur < r_rd) begin
                        r_lvl <= r_up; r_cur <= r_rd;
                        r_step <= 3'd5;
                        r_state <= S_DIVSET;
                    end else if (r_pick == 2'd3) begin
                        if (r_cur > r_rd) begin
                            r_lvl <= r_dn; r_cur <= r_rd;
                        end
                        r_step <= 3'd5;
                        r_state <= S_DIVSET;
                    end
                end
                S_DIVSET: begin
                    if (r_step == 3'd5) begin
                        r_step <= 3'd6;
                        r_mcand <= {32'b0, r_cur};
                        r_mplier <= {40'b0, r_seg};
                        r_acc <= '0; r_cnt <= '0;
                        r_state <= (r_avg != 0) ? S_MUL : S_FIN;
                    end else begin
                        r_rem <= '0; r_quo <= r_acc; r_cnt <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if ({r_rem[62:0], r_quo[63]} >= {32'b0, r_avg}) begin
                        r_rem <= {r_rem[62:0], r_quo[63]} - {32'b0, r_avg};
                        r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[62:0], r_quo[63]};
                        r_quo <= {r_quo[62:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd63) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (r_avg == 0) r_nint <= '0;
                    else r_nint <= nint_v;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_res <= '{chosen_index: r_lvl, chosen_rate: r_cur, probe_rate: r_tgt,
                               smoothed_rate: r_avg, request_interval: r_nint};
                    r_res_v <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A result is never overwritten before its transfer.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_v && !o_out.ready |=> r_res_v && $stable(r_res))
        else $error("result changed while stalled");
    // Input is only taken when the block is free.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !i_in.ready)
        else $error("ready while busy");
    // A result appears only when leaving the output state.
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_res_v) |-> $past(r_state) == S_OUT)
        else $error("unexpected result");
endmodule
`default_nettype wire

[sim/tb_probe_and_adapt_rate_selector_core.sv]
// Testbench for probe_and_adapt_rate_selector_core: random and directed ladder loads and
// throughput reports, predicted in a scoreboard class and checked field by field.
// Depends on pars_pkg, pars_if and the core.
`timescale 1ns / 100ps
module tb_probe_and_adapt_rate_selector_core;
    import pars_pkg::*;

    localparam int DEPTH      = 16;
    localparam int DRAIN_WAIT = 300;
    localparam int HOLD_LEN   = 3000;
    localparam int STALL_MAX  = 20000;
    localparam int PHASES     = 10;
    localparam int PHASE_ITEMS = 130;

    // Bit-exact predictor of the selector plus the queue of pending expected results.
    class rate_scoreboard;
        longint     regs[8];
        bit [31:0]  ladder[DEPTH];
        bit [31:0]  target_r, average_r, current_r, interval_r;
        bit [3:0]   level_r;
        t_out       pending_q[$];
        int         errors;

        function new();
            regs = '{13107, 13107, 9175, 0, 9830, 44, 131072, 1};
            foreach (ladder[i]) ladder[i] = '0;
            target_r = '0; average_r = '0; current_r = '0; interval_r = '0; level_r = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, longint val);
            int widths[8];
            widths = '{16, 16, 16, 24, 16, 16, 24, 5};
            regs[idx] = val & ((64'sd1 <<< widths[idx]) - 1);
        endfunction

        function longint clip32(longint v);
            if (v < 0) return 0;
            if (v > 64'sd4294967295) return 64'sd4294967295;
            return v;
        endfunction

        // Step of d scaled by a Q0.16 gain times a Q16.16 interval; negative steps round down.
        function longint scaled_step(longint d, longint gain, longint t);
            longint unsigned g, mag, p;
            g   = (longint'(gain) * longint'(t)) >> 16;
            mag = (d < 0) ? -d : d;
            p   = mag * g;
            if (d < 0) return -longint'((p + 64'hFFFF) >> 16);
            return longint'(p >> 16);
        endfunction

        function int walk_level(longint thr, int n);
            for (int i = 0; i < n; i++) begin
                if (longint'(ladder[i]) * 65536 > thr) return (i > 0) ? i - 1 : 0;
            end
            return n - 1;
        endfunction

        function void update_report(t_in it);
            longint t, over, d, w, thr_dn, thr_up, q, fb;
            int n, up, dn;
            w = regs[REG_W];
            t = (interval_r > it.fetch_time) ? interval_r : it.fetch_time;
            if (target_r != 0) begin
                over = longint'(target_r) - longint'(it.measured_rate);
                if (over < 0) over = 0;
                d = w - over;
                target_r = 32'(clip32(longint'(target_r)
                                      + scaled_step(d, regs[REG_KAPPA], t)));
            end else begin
                target_r = it.measured_rate;
            end
            if (average_r != 0) begin
                d = longint'(target_r) - longint'(average_r);
                average_r = 32'(clip32(longint'(average_r)
                                       + scaled_step(d, regs[REG_ALPHA], t)));
            end else begin
                average_r = target_r;
            end
            // A count of zero behaves as one, and anything past the depth is clamped.
            n = int'(regs[REG_COUNT]);
            if (n == 0) n = 1;
            if (n > DEPTH) n = DEPTH;
            thr_dn = longint'(average_r) * 65536 - w * 65536;
            thr_up = thr_dn - longint'(average_r) * regs[REG_EPS];
            up = walk_level(thr_up, n);
            dn = walk_level(thr_dn, n);
            if (current_r < ladder[up]) begin
                level_r = 4'(up); current_r = ladder[up];
            end else if (current_r > ladder[dn]) begin
                level_r = 4'(dn); current_r = ladder[dn];
            end
            if (average_r != 0) begin
                q = (longint'(current_r) * regs[REG_SEG]) / longint'(average_r);
                if (q > 64'sd4294967295) q = 64'sd4294967295;
                fb = regs[REG_BETA] * (longint'(it.buffer_level) - regs[REG_BMIN]);
                interval_r = 32'(clip32(q + fb));
            end else begin
                interval_r = '0;
            end
        endfunction

        function void note_input(t_in it);
            t_out r;
            if (it.op == OP_LOAD) begin
                if (it.entry_index < DEPTH) ladder[it.entry_index] = it.entry_rate;
            end else begin
                update_report(it);
            end
            r.chosen_index = level_r;
            r.chosen_rate = current_r;
            r.probe_rate = target_r;
            r.smoothed_rate = average_r;
            r.request_interval = interval_r;
            pending_q.push_back(r);
        endfunction

        function void check_result(t_out got);
            t_out e;
            if (pending_q.size() == 0) begin
                $error("unexpected result transfer %h", got);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (got.chosen_index !== e.chosen_index) begin
                $error("chosen_index exp %0d got %0d", e.chosen_index, got.chosen_index);
                errors++;
            end
            if (got.chosen_rate !== e.chosen_rate) begin
                $error("chosen_rate exp %0d got %0d", e.chosen_rate, got.chosen_rate);
                errors++;
            end
            if (got.probe_rate !== e.probe_rate) begin
                $error("probe_rate exp %0d got %0d", e.probe_rate, got.probe_rate);
                errors++;
            end
            if (got.smoothed_rate !== e.smoothed_rate) begin
                $error("smoothed_rate exp %0d got %0d", e.smoothed_rate, got.smoothed_rate);
                errors++;
            end
            if (got.request_interval !== e.request_interval) begin
                $error("request_interval exp %0d got %0d", e.request_interval,
                       got.request_interval);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    pars_if #(.T(t_in))  in_if (i_clk);
    pars_if #(.T(t_out)) out_if (i_clk);

    probe_and_adapt_rate_selector_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    rate_scoreboard sb = new();
    bit  calm = 1'b0;       // no idling on either side while set
    int  results_seen = 0;
    int  stall_cycles = 0;

    always #1 i_clk = ~i_clk;

    initial begin
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
    end

    // Monitor: every transfer is seen at the rising edge, before the core updates.
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) sb.note_input(in_if.data);
        if (i_rst_n && out_if.valid && out_if.ready) begin
            sb.check_result(out_if.data);
            results_seen++;
        end
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_MAX) begin
            $display("tb_probe_and_adapt_rate_selector_core: done, errors");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off so that the core
    // fills up and has to stall its input while the sender keeps offering.
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(negedge i_clk) begin
        if (!hold_done && results_seen >= 300) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready = 1'b0;
        end else begin
            out_if.ready = calm || ($urandom_range(99) >= 14);
        end
    end

    // Offers one item at the falling edge and returns at the falling edge after its transfer.
    task automatic push_item(input t_in it);
        while (!calm && $urandom_range(99) < 14) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid = 1'b1;
        in_if.data = it;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input longint val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val[CFG_DATA_W-1:0];
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // The core is idle once every expected result is back and its latency has passed.
    task automatic drain();
        in_if.valid = 1'b0;
        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic load_entry(input int idx, input bit [31:0] rate);
        t_in it;
        it = '0;
        it.op = OP_LOAD;
        it.entry_index = 4'(idx);
        it.entry_rate = rate;
        it.measured_rate = $urandom;
        it.fetch_time = $urandom;
        it.buffer_level = $urandom;
        push_item(it);
    endtask

    task automatic report(input bit [31:0] rate, input bit [31:0] ftime, input bit [15:0] buf_lvl);
        t_in it;
        it.op = ~OP_LOAD;
        it.entry_index = $urandom;
        it.entry_rate = $urandom;
        it.measured_rate = rate;
        it.fetch_time = ftime;
        it.buffer_level = buf_lvl;
        push_item(it);
    endtask

    // Reloads the whole ladder in ascending order at a random scale.
    task automatic build_ladder();
        int unsigned scale;
        scale = 1 << $urandom_range(27, 10);
        for (int i = 0; i < DEPTH; i++)
            load_entry(i, i * scale + $urandom_range(scale / 2));
    endtask

    task automatic random_item();
        int k, r;
        bit [31:0] lo, hi, top;
        r = $urandom_range(99);
        if (r < 12) begin
            // Keep the ladder ascending by landing between the neighbors.
            k = $urandom_range(DEPTH - 1);
            lo = (k > 0) ? sb.ladder[k-1] : 32'd0;
            hi = (k < DEPTH - 1) ? sb.ladder[k+1] : 32'hFFFF_FFFF;
            load_entry(k, (hi > lo) ? lo + $urandom_range(hi - lo) : lo);
        end else if (r < 15) begin
            load_entry($urandom_range(DEPTH - 1), $urandom);
        end else begin
            top = sb.ladder[DEPTH-1];
            top = (top > 32'hC000_0000) ? 32'hFFFF_FFFF : top + (top >> 2);
            report(($urandom_range(99) < 80) ? $urandom_range(top) : $urandom,
                   ($urandom_range(99) < 85) ? $urandom_range(4 * 65536) : $urandom,
                   ($urandom_range(99) < 85) ? $urandom_range(100) : $urandom);
        end
    endtask

    task automatic random_config(input int phase);
        case (phase)
            0: ;  // reset defaults
            1: begin
                write_reg(REG_ALPHA, 16'hFFFF); write_reg(REG_BETA, 16'hFFFF);
                write_reg(REG_KAPPA, 16'hFFFF); write_reg(REG_W, 24'hFF_FFFF);
                write_reg(REG_EPS, 16'hFFFF);   write_reg(REG_BMIN, 16'hFFFF);
                write_reg(REG_SEG, 24'hFF_FFFF); write_reg(REG_COUNT, DEPTH);
            end
            2: begin
                write_reg(REG_ALPHA, 0); write_reg(REG_BETA, 0);
                write_reg(REG_KAPPA, 0); write_reg(REG_W, 0);
                write_reg(REG_EPS, 0);   write_reg(REG_BMIN, 0);
                write_reg(REG_SEG, 0);   write_reg(REG_COUNT, 0);
            end
            default: begin
                write_reg(REG_ALPHA, $urandom_range(16'hFFFF));
                write_reg(REG_BETA, $urandom_range(16'hFFFF));
                write_reg(REG_KAPPA, $urandom_range(16'hFFFF));
                write_reg(REG_W, ($urandom_range(1)) ? $urandom_range(1 << 20)
                                                     : $urandom_range(24'hFF_FFFF));
                write_reg(REG_EPS, $urandom_range(16'hFFFF));
                write_reg(REG_BMIN, $urandom_range(100));
                write_reg(REG_SEG, $urandom_range(24'hFF_FFFF));
                // A count above the depth saturates; also lowers it under a held level.
                write_reg(REG_COUNT, (phase == 3) ? 31 : $urandom_range(20));
            end
        endcase
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part: full ladder with the extreme rates at its ends, then
        // reports at the extremes of each field, starting from the zero state.
        for (int i = 0; i < DEPTH; i++)
            load_entry(i, (i == 0) ? 32'd0 : (i == DEPTH - 1) ? 32'hFFFF_FFFF : i << 27);
        report(32'd0, 32'd0, 16'd0);
        report(32'h2000_0000, 32'd131072, 16'd44);
        report(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        report(32'd0, 32'hFFFF_FFFF, 16'd0);
        report(32'h7FFF_FFFF, 32'd0, 16'hFFFF);
        load_entry(5, 32'h0000_0001);
        report(32'h1000_0000, 32'd65536, 16'd10);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            random_config(p);
            calm = (p == 5);
            build_ladder();
            repeat (PHASE_ITEMS) random_item();
        end
        calm = 1'b0;

        drain();
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("tb_probe_and_adapt_rate_selector_core: done, clean");
        else
            $display("tb_probe_and_adapt_rate_selector_core: done, errors");
        $finish;
    end
endmodule
